>>> hdl/sfl_pkg.sv
`timescale 1ns / 1ps
// sfl_pkg: shared types and constants of the segment free list.
// No dependencies; every other file of the block but sfl_link_ram imports it.

package sfl_pkg;

	localparam int SEG_IDX_W = 6;
	localparam int LEN_W     = 32;

	// Cookie that a valid segment header carries; its low COOKIE_WIDTH bits are compared.
	localparam logic [31:0] HDR_COOKIE = 32'h00BA_AB00;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_REMOVE = 1'b1
	} sfl_op_t;

	typedef struct packed {
		logic                 accepted;
		logic                 list_empty;
		logic [SEG_IDX_W-1:0] head_entry;
	} sfl_result_t;

endpackage

>>> hdl/sfl_if.sv
`timescale 1ns / 1ps
// sfl_if: request and result channels of the segment free list, valid/ready.
// Depends on sfl_pkg for the field widths.

interface sfl_req_if import sfl_pkg::*; #(
	parameter int COOKIE_WIDTH = 24
) ();
	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic [SEG_IDX_W-1:0]    segment_index;
	logic [LEN_W-1:0]        segment_length;
	logic [COOKIE_WIDTH-1:0] header_cookie;

	modport source (output valid, operation, segment_index, segment_length, header_cookie,
		input ready);
	modport sink (input valid, operation, segment_index, segment_length, header_cookie,
		output ready);
endinterface

interface sfl_rsp_if import sfl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 accepted;
	logic                 list_empty;
	logic [SEG_IDX_W-1:0] head_entry;

	modport source (output valid, accepted, list_empty, head_entry, input ready);
	modport sink (input valid, accepted, list_empty, head_entry, output ready);
endinterface

>>> hdl/sfl_link_ram.sv
`timescale 1ns / 1ps
// sfl_link_ram: one-write one-read synchronous RAM for the link words.
// Read data is registered; no dependencies.

module sfl_link_ram #(
	parameter int  DEPTH = 64,
	parameter int  WIDTH = 7,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/sfl_seq.sv
`timescale 1ns / 1ps
// sfl_seq: sequencer of the free list: head register, list walk, link updates,
// and the clearing pass after reset. Depends on sfl_pkg; drives two sfl_link_ram.

module sfl_seq import sfl_pkg::*; #(
	parameter int  ENTRIES = 64,
	localparam int IW      = $clog2(ENTRIES),
	localparam int LW      = $clog2(ENTRIES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          start_op,
	input  logic          start_ok,
	input  logic [IW-1:0] start_idx,
	output logic          busy,
	input  logic          slot_free,
	output logic          done,
	output sfl_result_t   result,
	// next-link RAM, word = {free mark, link}
	output logic          nxt_we,
	output logic [IW-1:0] nxt_waddr,
	output logic [LW:0]   nxt_wdata,
	output logic [IW-1:0] nxt_raddr,
	input  logic [LW:0]   nxt_rdata,
	// prev-link RAM
	output logic          prv_we,
	output logic [IW-1:0] prv_waddr,
	output logic [LW-1:0] prv_wdata,
	output logic [IW-1:0] prv_raddr,
	input  logic [LW-1:0] prv_rdata
);

	localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);
	localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);

	typedef enum logic [9:0] {
		ST_CLEAR    = 10'b00_0000_0001,
		ST_IDLE     = 10'b00_0000_0010,
		ST_DISPATCH = 10'b00_0000_0100,
		ST_ADD_LINK = 10'b00_0000_1000,
		ST_ADD_HEAD = 10'b00_0001_0000,
		ST_WALK     = 10'b00_0010_0000,
		ST_UNL_RD   = 10'b00_0100_0000,
		ST_UNL_WR   = 10'b00_1000_0000,
		ST_UNL_CLR  = 10'b01_0000_0000,
		ST_DONE     = 10'b10_0000_0000
	} seq_state_t;

	seq_state_t    state_q, state_d;
	logic [IW-1:0] head_q, head_d;
	logic          head_valid_q, head_valid_d;
	logic          acc_q, acc_d;
	logic          is_head_q, is_head_d;
	logic          first_q, first_d;
	logic [LW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] clr_q, clr_d;
	logic [IW-1:0] s_q;
	logic          op_q;
	logic          ok_q;

	logic [LW-1:0] walk_t;
	logic [LW-1:0] link_p;
	logic [LW-1:0] link_n;

	function automatic logic is_entry(input logic [LW-1:0] v);
		return v < NULL_LINK;
	endfunction

	assign walk_t = first_q ? LW'(head_q) : nxt_rdata[LW-1:0];
	assign link_p = prv_rdata;
	assign link_n = nxt_rdata[LW-1:0];

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		head_valid_d = head_valid_q;
		acc_d        = acc_q;
		is_head_d    = is_head_q;
		first_d      = first_q;
		cnt_d        = cnt_q;
		clr_d        = clr_q;
		done         = 1'b0;
		nxt_we       = 1'b0;
		nxt_waddr    = s_q;
		nxt_wdata    = {1'b0, NULL_LINK};
		nxt_raddr    = s_q;
		prv_we       = 1'b0;
		prv_waddr    = s_q;
		prv_wdata    = NULL_LINK;
		prv_raddr    = s_q;

		case (state_q)
			ST_CLEAR: begin
				nxt_we    = 1'b1;
				nxt_waddr = clr_q;
				prv_we    = 1'b1;
				prv_waddr = clr_q;
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + IW'(1);
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!ok_q) begin
					acc_d   = 1'b0;
					state_d = ST_DONE;
				end else if (op_q == OP_ADD) begin
					state_d = ST_ADD_LINK;
				end else if (!head_valid_q) begin
					acc_d   = 1'b0;
					state_d = ST_DONE;
				end else if (head_q == s_q) begin
					is_head_d = 1'b1;
					state_d   = ST_UNL_RD;
				end else begin
					first_d = 1'b1;
					cnt_d   = '0;
					state_d = ST_WALK;
				end
			end
			ST_ADD_LINK: begin
				nxt_we    = 1'b1;
				nxt_wdata = {1'b1, head_valid_q ? LW'(head_q) : NULL_LINK};
				if (head_valid_q) begin
					prv_we    = 1'b1;
					prv_waddr = head_q;
					prv_wdata = LW'(s_q);
				end
				state_d = ST_ADD_HEAD;
			end
			ST_ADD_HEAD: begin
				// separate cycle: prev[s] must land after prev[head] for a duplicate add
				prv_we       = 1'b1;
				head_d       = s_q;
				head_valid_d = 1'b1;
				acc_d        = 1'b1;
				state_d      = ST_DONE;
			end
			ST_WALK: begin
				// one link per cycle: the next address comes straight from read data
				nxt_raddr = walk_t[IW-1:0];
				if (cnt_q == NULL_LINK || !is_entry(walk_t)) begin
					acc_d   = 1'b0;
					state_d = ST_DONE;
				end else if (walk_t == LW'(s_q)) begin
					is_head_d = 1'b0;
					state_d   = ST_UNL_RD;
				end else begin
					cnt_d   = cnt_q + LW'(1);
					first_d = 1'b0;
				end
			end
			ST_UNL_RD: begin
				state_d = ST_UNL_WR;
			end
			ST_UNL_WR: begin
				if (is_head_q) begin
					if (is_entry(link_n)) begin
						head_d    = link_n[IW-1:0];
						prv_we    = 1'b1;
						prv_waddr = link_n[IW-1:0];
					end else begin
						head_d       = '0;
						head_valid_d = 1'b0;
					end
				end else begin
					if (is_entry(link_p)) begin
						nxt_we    = 1'b1;
						nxt_waddr = link_p[IW-1:0];
						nxt_wdata = {1'b1, link_n};
					end
					if (is_entry(link_n)) begin
						prv_we    = 1'b1;
						prv_waddr = link_n[IW-1:0];
						prv_wdata = link_p;
					end
				end
				state_d = ST_UNL_CLR;
			end
			ST_UNL_CLR: begin
				nxt_we  = 1'b1;
				prv_we  = 1'b1;
				acc_d   = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	assign result.accepted   = acc_q;
	assign result.list_empty = !head_valid_q;
	assign result.head_entry = head_valid_q ? SEG_IDX_W'(head_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			head_q       <= '0;
			head_valid_q <= 1'b0;
			acc_q        <= 1'b0;
			is_head_q    <= 1'b0;
			first_q      <= 1'b0;
			cnt_q        <= '0;
			clr_q        <= '0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			head_valid_q <= head_valid_d;
			acc_q        <= acc_d;
			is_head_q    <= is_head_d;
			first_q      <= first_d;
			cnt_q        <= cnt_d;
			clr_q        <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			s_q  <= start_idx;
			op_q <= start_op;
			ok_q <= start_ok;
		end
	end

endmodule

>>> hdl/segment_free_list_unit.sv
`timescale 1ns / 1ps
// segment_free_list_unit: top level of the segment free list.
// Depends on sfl_pkg, sfl_if, sfl_link_ram and sfl_seq.

// The list lives in two link RAMs (next with free mark, prev) of ENTRIES words
// and a head register. After reset a clearing pass writes null links to every
// entry, during which req.ready stays low; cfg writes are taken at any time.
// Requests are handled one at a time, from the request transfer to the result
// appearing on rsp. A request that fails the index, header or length check,
// and a remove on an empty list, is rejected without touching the links; an
// add and a remove of the head need no walk, any other remove follows links
// from the head, and one that misses ends at the end of the list or after
// ENTRIES links. The walk is bounded by the registered read of the next-link
// RAM, one link per cycle. The result sits in an output register, so a new
// request is taken while the previous result waits for rsp.ready.

module segment_free_list_unit import sfl_pkg::*; #(
	parameter int ENTRIES      = 64,
	parameter int COOKIE_WIDTH = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [LEN_W-1:0]  cfg_wr_data,
	sfl_req_if.sink           req,
	sfl_rsp_if.source         rsp
);

	localparam int IW = $clog2(ENTRIES);
	localparam int LW = $clog2(ENTRIES + 1);

	logic [LEN_W-1:0] list_size_q;
	logic             rsp_valid_q;
	sfl_result_t      rsp_q;

	logic          start;
	logic          start_ok;
	logic          busy;
	logic          slot_free;
	logic          done;
	sfl_result_t   result;

	logic          nxt_we;
	logic [IW-1:0] nxt_waddr;
	logic [LW:0]   nxt_wdata;
	logic [IW-1:0] nxt_raddr;
	logic [LW:0]   nxt_rdata;
	logic          prv_we;
	logic [IW-1:0] prv_waddr;
	logic [LW-1:0] prv_wdata;
	logic [IW-1:0] prv_raddr;
	logic [LW-1:0] prv_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_size_q <= '0;
		end else if (cfg_wr_en) begin
			list_size_q <= cfg_wr_data;
		end
	end

	assign req.ready = !busy;
	assign start     = req.valid && req.ready;

	// index range, cookie and length checks
	assign start_ok = (32'(req.segment_index) < 32'(ENTRIES))
		&& (req.header_cookie == HDR_COOKIE[COOKIE_WIDTH-1:0])
		&& (req.segment_length == list_size_q);

	assign slot_free = !rsp_valid_q || rsp.ready;

	sfl_seq #(
		.ENTRIES (ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_op  (req.operation),
		.start_ok  (start_ok),
		.start_idx (IW'(req.segment_index)),
		.busy      (busy),
		.slot_free (slot_free),
		.done      (done),
		.result    (result),
		.nxt_we    (nxt_we),
		.nxt_waddr (nxt_waddr),
		.nxt_wdata (nxt_wdata),
		.nxt_raddr (nxt_raddr),
		.nxt_rdata (nxt_rdata),
		.prv_we    (prv_we),
		.prv_waddr (prv_waddr),
		.prv_wdata (prv_wdata),
		.prv_raddr (prv_raddr),
		.prv_rdata (prv_rdata)
	);

	sfl_link_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (LW + 1)
	) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (nxt_raddr),
		.rdata (nxt_rdata)
	);

	sfl_link_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (LW)
	) u_prev_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.raddr (prv_raddr),
		.rdata (prv_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.accepted   = rsp_q.accepted;
	assign rsp.list_empty = rsp_q.list_empty;
	assign rsp.head_entry = rsp_q.head_entry;

endmodule

>>> hdl/sfl_checker.sv
`timescale 1ns / 1ps
// sfl_checker: port-level checks of segment_free_list_unit, attached by bind.
// Depends on sfl_pkg for the result field widths.

module sfl_checker import sfl_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic                 rsp_list_empty,
	input logic [SEG_IDX_W-1:0] rsp_head_entry
);

	logic       req_xfer;
	logic       rsp_xfer;
	logic [1:0] pending_q;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	// requests taken minus results delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_xfer && !rsp_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (rsp_xfer && !req_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("result without a request");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than one request in flight besides a waiting result");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_list_empty |-> rsp_head_entry == '0)
		else $error("empty list reports a nonzero head");

endmodule

bind segment_free_list_unit sfl_checker u_sfl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_list_empty (rsp.list_empty),
	.rsp_head_entry (rsp.head_entry)
);

>>> tb/segment_free_list_unit_tb.sv
`timescale 1ns / 1ps
// segment_free_list_unit_tb: self-checking bench for the segment free list unit.
// Drives directed and random add/remove traffic and checks each result against a
// behavioral linked-list model. Depends on sfl_pkg, sfl_if and segment_free_list_unit.

module segment_free_list_unit_tb;
	import sfl_pkg::*;

	localparam int ENTRIES       = 64;
	localparam int COOKIE_WIDTH  = 24;
	localparam int LINK_W        = 7;
	localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(ENTRIES);
	localparam logic [COOKIE_WIDTH-1:0] GOOD_COOKIE = HDR_COOKIE[COOKIE_WIDTH-1:0];
	localparam int SETTLE_CYCLES = ENTRIES + 16;
	localparam int CYCLE_LIMIT   = 1_000_000;

	typedef enum logic [1:0] {
		FLAW_NONE,
		FLAW_COOKIE,
		FLAW_LENGTH
	} req_flaw_t;

	typedef struct packed {
		sfl_op_t                 op;
		logic [SEG_IDX_W-1:0]    idx;
		logic [LEN_W-1:0]        len;
		logic [COOKIE_WIDTH-1:0] cookie;
	} seg_req_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;

	sfl_req_if #(.COOKIE_WIDTH(COOKIE_WIDTH)) req_ch ();
	sfl_rsp_if rsp_ch ();

	segment_free_list_unit #(
		.ENTRIES(ENTRIES),
		.COOKIE_WIDTH(COOKIE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the list
	logic [LEN_W-1:0]     cfg_list_size;
	logic [SEG_IDX_W-1:0] head_ptr;
	logic                 head_valid;
	logic [LINK_W-1:0]    next_lk [ENTRIES];
	logic [LINK_W-1:0]    prev_lk [ENTRIES];
	logic                 free_mark [ENTRIES];

	seg_req_t    pending_reqs[$];
	sfl_result_t expected_results[$];
	seg_req_t    on_bus;
	sfl_result_t want;
	int          queued_cnt;
	int          accepted_cnt;
	int          mismatch_cnt;
	int          cycle_cnt;
	bit          calm;
	bit          in_list_gen [ENTRIES];

	function automatic sfl_result_t predict_free_list(seg_req_t r);
		sfl_result_t       res;
		logic [LINK_W-1:0] walk, p, n;
		logic              found;
		found = 1'b0;
		if (r.cookie == GOOD_COOKIE && r.len == cfg_list_size) begin
			if (r.op == OP_ADD) begin
				if (head_valid) begin
					next_lk[r.idx] = {1'b0, head_ptr};
					prev_lk[head_ptr] = {1'b0, r.idx};
				end else begin
					next_lk[r.idx] = NO_LINK;
				end
				prev_lk[r.idx] = NO_LINK;
				head_ptr = r.idx;
				head_valid = 1'b1;
				free_mark[r.idx] = 1'b1;
				found = 1'b1;
			end else if (head_valid) begin
				if (r.idx == head_ptr) begin
					n = next_lk[r.idx];
					if (n < NO_LINK) begin
						head_ptr = n[SEG_IDX_W-1:0];
						prev_lk[n[SEG_IDX_W-1:0]] = NO_LINK;
					end else begin
						head_ptr = '0;
						head_valid = 1'b0;
					end
					found = 1'b1;
				end else begin
					// membership walk, bounded to ENTRIES links since duplicates can loop
					walk = {1'b0, head_ptr};
					for (int k = 0; k < ENTRIES && walk < NO_LINK && !found; k++) begin
						if (walk[SEG_IDX_W-1:0] == r.idx)
							found = 1'b1;
						else
							walk = next_lk[walk[SEG_IDX_W-1:0]];
					end
					if (found) begin
						p = prev_lk[r.idx];
						n = next_lk[r.idx];
						if (p < NO_LINK) next_lk[p[SEG_IDX_W-1:0]] = n;
						if (n < NO_LINK) prev_lk[n[SEG_IDX_W-1:0]] = p;
					end
				end
				if (found) begin
					next_lk[r.idx] = NO_LINK;
					prev_lk[r.idx] = NO_LINK;
					free_mark[r.idx] = 1'b0;
				end
			end
		end
		res.accepted = found;
		res.list_empty = !head_valid;
		res.head_entry = head_valid ? head_ptr : '0;
		return res;
	endfunction

	function automatic void queue_request(sfl_op_t op, int idx, req_flaw_t flaw);
		seg_req_t r;
		r.op = op;
		r.idx = SEG_IDX_W'(idx);
		r.len = cfg_list_size;
		r.cookie = GOOD_COOKIE;
		case (flaw)
			FLAW_COOKIE: begin
				if ($urandom_range(1))
					r.cookie = GOOD_COOKIE ^ (COOKIE_WIDTH'(1) << $urandom_range(COOKIE_WIDTH-1));
				else begin
					r.cookie = COOKIE_WIDTH'($urandom());
					if (r.cookie == GOOD_COOKIE) r.cookie[0] = ~r.cookie[0];
				end
			end
			FLAW_LENGTH: begin
				if ($urandom_range(1))
					r.len = cfg_list_size ^ (LEN_W'(1) << $urandom_range(LEN_W-1));
				else begin
					r.len = $urandom();
					if (r.len == cfg_list_size) r.len[0] = ~r.len[0];
				end
			end
			default: begin
				in_list_gen[r.idx] = (op == OP_ADD);
			end
		endcase
		pending_reqs.push_back(r);
		queued_cnt++;
	endfunction

	// mostly a live member, now and then any entry
	function automatic int pick_member();
		int members[$];
		for (int i = 0; i < ENTRIES; i++)
			if (in_list_gen[i]) members.push_back(i);
		if (members.size() == 0 || $urandom_range(7) == 0)
			return $urandom_range(ENTRIES-1);
		return members[$urandom_range(members.size()-1)];
	endfunction

	task automatic run_random_phase(int count, int pool_hi);
		int r;
		int idx;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				idx = $urandom_range(pool_hi);
				if (in_list_gen[idx] && $urandom_range(9) != 0) idx = $urandom_range(pool_hi);
				queue_request(OP_ADD, idx, FLAW_NONE);
			end else if (r < 85) begin
				queue_request(OP_REMOVE, pick_member(), FLAW_NONE);
			end else begin
				queue_request(sfl_op_t'($urandom_range(1)), $urandom_range(ENTRIES-1),
					req_flaw_t'($urandom_range(1, 2)));
			end
		end
	endtask

	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_list_size(logic [LEN_W-1:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_list_size = v;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(predict_free_list(on_bus));
				accepted_cnt++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
					on_bus = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= on_bus.op;
					req_ch.segment_index <= on_bus.idx;
					req_ch.segment_length <= on_bus.len;
					req_ch.header_cookie <= on_bus.cookie;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result accepted=%0b list_empty=%0b head_entry=%0d",
						$time, rsp_ch.accepted, rsp_ch.list_empty, rsp_ch.head_entry);
					mismatch_cnt++;
				end else begin
					want = expected_results.pop_front();
					if (rsp_ch.accepted !== want.accepted) begin
						$display("%0t: accepted expected %0b got %0b",
							$time, want.accepted, rsp_ch.accepted);
						mismatch_cnt++;
					end
					if (rsp_ch.list_empty !== want.list_empty) begin
						$display("%0t: list_empty expected %0b got %0b",
							$time, want.list_empty, rsp_ch.list_empty);
						mismatch_cnt++;
					end
					if (rsp_ch.head_entry !== want.head_entry) begin
						$display("%0t: head_entry expected %0d got %0d",
							$time, want.head_entry, rsp_ch.head_entry);
						mismatch_cnt++;
					end
				end
			end
			rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("segment_free_list_unit test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = 1'b0;
		req_ch.segment_index = '0;
		req_ch.segment_length = '0;
		req_ch.header_cookie = '0;
		rsp_ch.ready = 1'b0;
		calm = 1'b0;
		queued_cnt = 0;
		accepted_cnt = 0;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		cfg_list_size = '0;
		head_ptr = '0;
		head_valid = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			next_lk[i] = NO_LINK;
			prev_lk[i] = NO_LINK;
			free_mark[i] = 1'b0;
			in_list_gen[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty list, bad headers, head/middle/tail unlink, cycles
		write_list_size('0);
		queue_request(OP_REMOVE, 5, FLAW_NONE);
		queue_request(OP_ADD, 0, FLAW_COOKIE);
		queue_request(OP_ADD, 0, FLAW_LENGTH);
		queue_request(OP_ADD, 0, FLAW_NONE);
		queue_request(OP_ADD, 63, FLAW_NONE);
		queue_request(OP_ADD, 17, FLAW_NONE);
		queue_request(OP_REMOVE, 63, FLAW_LENGTH);
		queue_request(OP_REMOVE, 63, FLAW_NONE);
		queue_request(OP_REMOVE, 0, FLAW_NONE);
		queue_request(OP_REMOVE, 17, FLAW_NONE);
		queue_request(OP_ADD, 1, FLAW_NONE);
		queue_request(OP_ADD, 2, FLAW_NONE);
		queue_request(OP_ADD, 3, FLAW_NONE);
		queue_request(OP_REMOVE, 1, FLAW_NONE);
		queue_request(OP_REMOVE, 5, FLAW_NONE);
		queue_request(OP_REMOVE, 3, FLAW_NONE);
		// re-adding the sole head links it to itself; a miss then walks the full bound
		queue_request(OP_ADD, 2, FLAW_NONE);
		queue_request(OP_REMOVE, 40, FLAW_NONE);
		queue_request(OP_REMOVE, 2, FLAW_NONE);
		queue_request(OP_REMOVE, 2, FLAW_NONE);
		queue_request(OP_REMOVE, 2, FLAW_NONE);

		write_list_size('1);
		run_random_phase(300, ENTRIES-1);
		write_list_size($urandom());
		run_random_phase(300, 7);
		calm = 1'b1;
		write_list_size(LEN_W'(ENTRIES));
		run_random_phase(300, ENTRIES-1);
		wait_idle();
		calm = 1'b0;
		write_list_size($urandom());
		run_random_phase(300, ENTRIES-1);
		write_list_size('0);
		run_random_phase(300, 15);
		wait_idle();

		if (mismatch_cnt == 0)
			$display("segment_free_list_unit test passed");
		else
			$display("segment_free_list_unit test failed");
		$finish;
	end

endmodule
